### rtl/core/ratc_pkg.sv
// Package for the row activation threshold counter.
// Holds the transaction structs, register map constants and default sizes.
// No dependencies.
package ratc_pkg;

	localparam int DEF_NUM_BANKS = 16;
	localparam int DEF_NUM_ROWS  = 65536;

	localparam int CNT_W    = 32;
	localparam int THRESH_W = 5;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd16;

	// word index of each register (byte address 4*i)
	localparam logic [PADDR_W-3:0] REG_THRESHOLD_BIT = 1'b0;

	localparam logic REQ_ACTIVATE = 1'b0;

	typedef struct packed {
		logic        req_type;
		logic        bank_valid;
		logic [3:0]  bank;
		logic [15:0] row;
		logic [5:0]  src_id;
	} req_t;

	typedef struct packed {
		logic [5:0]  alert_source;
		logic [3:0]  alert_bank;
		logic [15:0] alert_row;
		logic        alert_level;
	} alert_t;

endpackage

### rtl/core/row_activation_threshold_counter.sv
// Top level of the row activation threshold counter.
// Uses ratc_pkg; one counter memory, one read-modify-write stage, alert register.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------
//   request  | req_valid / req_ready       | req   (ratc_pkg::req_t)
//   alert    | alert_valid / alert_ready   | alert (ratc_pkg::alert_t)
//   config   | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// One request per cycle unless stalled, set by the memory's single read and write port.
// An activate is read at acceptance and written back when its stage advances; the alert
// register loads at that same edge. Back-to-back activates of one row are forwarded.
// After reset a clearing pass zeroes all NUM_BANKS*NUM_ROWS counter entries
// (1048576 by default) with req_ready low. Requests stall while a pending alert
// is blocked by a full alert register.
module row_activation_threshold_counter #(
	parameter int NUM_BANKS = ratc_pkg::DEF_NUM_BANKS,
	parameter int NUM_ROWS  = ratc_pkg::DEF_NUM_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ratc_pkg::req_t                req,
	output logic                          alert_valid,
	input  logic                          alert_ready,
	output ratc_pkg::alert_t              alert,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ratc_pkg::PADDR_W-1:0]  paddr,
	input  logic [ratc_pkg::PDATA_W-1:0]  pwdata,
	output logic [ratc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ratc_pkg::*;

	localparam int DEPTH  = NUM_BANKS * NUM_ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	logic [CNT_W-1:0] mem [DEPTH];

	logic [THRESH_W-1:0] thresh_q;
	logic                clearing_q;
	logic [ADDR_W-1:0]   clr_addr_q;

	logic                v_s1;
	logic [ADDR_W-1:0]   addr_s1;
	req_t                req_s1;
	logic [CNT_W-1:0]    rd_data_s1;
	logic                fwd_hit_s1;
	logic [CNT_W-1:0]    fwd_data_s1;

	logic                alert_valid_q;
	alert_t              alert_q;

	logic                req_hit;
	logic [ADDR_W-1:0]   req_addr;
	logic                req_fire;
	logic                load;
	logic [CNT_W-1:0]    before_s1;
	logic [CNT_W-1:0]    after_s1;
	logic                alert_s1;
	logic                s1_go;
	logic                cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[PADDR_W-1:2] == REG_THRESHOLD_BIT) ?
		PDATA_W'(thresh_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_THRESHOLD_BIT) begin
			thresh_q <= pwdata[THRESH_W-1:0];
		end
	end

	// request decode
	always_comb begin
		req_hit = (req.req_type == REQ_ACTIVATE) && req.bank_valid &&
			(32'(req.bank) < 32'(NUM_BANKS)) && (32'(req.row) < 32'(NUM_ROWS));
		req_addr = ADDR_W'(ADDR_W'(req.bank) * ADDR_W'(NUM_ROWS) + ADDR_W'(req.row));
	end

	// modify stage
	always_comb begin
		before_s1 = fwd_hit_s1 ? fwd_data_s1 : rd_data_s1;
		after_s1  = before_s1 + CNT_W'(1);
		alert_s1  = before_s1[thresh_q] ^ after_s1[thresh_q];
		s1_go     = v_s1 && (!alert_s1 || !alert_valid_q || alert_ready);
		req_ready = !clearing_q && (!v_s1 || s1_go);
		req_fire  = req_valid && req_ready;
		load      = req_fire && req_hit;
	end

	// counter memory: clearing pass, write-back, read at acceptance
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (s1_go) begin
			mem[addr_s1] <= after_s1;
		end
		if (load) begin
			rd_data_s1 <= mem[req_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
				// the read above misses the write-back of the same edge
				fwd_hit_s1 <= v_s1 && (addr_s1 == req_addr);
			end else if (s1_go) begin
				v_s1       <= 1'b0;
				fwd_hit_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_s1     <= req_addr;
			req_s1      <= req;
			fwd_data_s1 <= after_s1;
		end
	end

	// alert register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_valid_q <= 1'b0;
		end else if (s1_go && alert_s1) begin
			alert_valid_q <= 1'b1;
		end else if (alert_ready) begin
			alert_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && alert_s1) begin
			alert_q.alert_source <= req_s1.src_id;
			alert_q.alert_bank   <= req_s1.bank;
			alert_q.alert_row    <= req_s1.row;
			alert_q.alert_level  <= after_s1[thresh_q];
		end
	end

	assign alert_valid = alert_valid_q;
	assign alert       = alert_q;

`ifndef SYNTHESIS
	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req_ready) else $error("request taken during clearing pass");

	a_no_stage_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !clearing_q) else $error("write-back stage busy during clearing pass");

	a_fwd_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit_s1 |-> v_s1) else $error("forward hit without a staged activate");

	a_alert_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(alert_valid_q) |-> $past(v_s1)) else $error("alert without a staged activate");

	a_blocked_alert_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && alert_s1 && alert_valid_q && !alert_ready) |-> !req_ready)
		else $error("request taken while alert path blocked");
`endif

endmodule
